[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SUMD_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SUMD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/sumd_pkg.sv]
// ----------------------------------------------------------------------------
// SUMD parser package
// Widths, register indexes, the result item type and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package sumd_pkg;

   // Default channel limit of a frame.
   localparam int MAX_CHANNELS_DEFAULT = 16;

   // Field widths.
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 5;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 6;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_BYTE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIVE_STATUS = 2'd1;
   localparam logic [BYTE_W-1:0] HEADER_BYTE_RESET = 8'd168;
   localparam logic [BYTE_W-1:0] LIVE_STATUS_RESET = 8'd1;

   // CRC-16, polynomial 0x1021, MSB first.
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Entries of the queue between the scanner and the response port.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [INDEX_W-1:0] channel_index;
      logic [VALUE_W-1:0] channel_value;
      logic [COUNT_W-1:0] channel_count;
      logic               channel_valid;
      logic               last_of_frame;
   } rsp_item_type;

   // One entry pushed from the scanner into the queue.
   typedef struct packed {
      logic         push;
      rsp_item_type item;
   } push_type;

   // Advance the CRC over one byte, eight bit steps.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i,
                                              input logic [BYTE_W-1:0] data_i);
      logic [15:0] c;
      c = crc_i ^ {data_i, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[hdl/sumd_if.sv]
// ----------------------------------------------------------------------------
// SUMD parser channels
// Valid/ready channels for received bytes and decoded channel results.
// ----------------------------------------------------------------------------

// Received byte channel.
interface sumd_req_if import sumd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded channel result channel.
interface sumd_rsp_if import sumd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] channel_index;
   logic [VALUE_W-1:0] channel_value;
   logic [COUNT_W-1:0] channel_count;
   logic               channel_valid;
   logic               last_of_frame;

   modport source (output valid, output channel_index, output channel_value,
                   output channel_count, output channel_valid,
                   output last_of_frame, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input channel_count, input channel_valid,
                   input last_of_frame, output ready);
endinterface

[hdl/sumd_frame_parser.sv]
// ----------------------------------------------------------------------------
// SUMD frame parser
// Scans received bytes for CRC-checked frames and returns channel words.
// ----------------------------------------------------------------------------
// One request carries one received byte; it is stored in a window of
// 5 + 2*MAX_CHANNELS bytes and the window is then scanned from its oldest
// byte over a single read port. A new request is taken only once the scan
// has finished. A start byte may fail, or end the scan, before the CRC pass;
// a start byte with a complete frame of n channels behind it goes through
// the CRC pass and check, and a live frame then emits one result per channel
// (one empty result for a frame without channels), held while the result
// queue is full. A dropped start byte restarts the scan. Results pass
// through a four-entry queue, so the response side may stall freely while
// the scanner works. No clearing pass follows reset.
module sumd_frame_parser import sumd_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   sumd_req_if.sink               req_bus,
   sumd_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [BYTE_W-1:0] header_byte_ff;
   logic [BYTE_W-1:0] live_status_ff;
   push_type          push;
   logic              queue_full;

   // Configuration registers; writes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= HEADER_BYTE_RESET;
         live_status_ff <= LIVE_STATUS_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_HEADER_BYTE) begin
            header_byte_ff <= csr_wdata;
         end
         if (csr_index == CSR_LIVE_STATUS) begin
            live_status_ff <= csr_wdata;
         end
      end
   end

   // Front: byte window and frame scan.
   sumd_scanner #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_scanner (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .header_byte (header_byte_ff),
      .live_status (live_status_ff),
      .push_o      (push),
      .queue_full  (queue_full)
   );

   // Back: result queue feeding the response port.
   sumd_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .full   (queue_full),
      .rsp    (rsp_bus)
   );

endmodule

[hdl/sumd_scanner.sv]
// ----------------------------------------------------------------------------
// SUMD frame scanner
// Stores received bytes in a circular window, finds and checks frames and
// pushes the channel words of live frames into the result queue.
// ----------------------------------------------------------------------------
module sumd_scanner import sumd_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   sumd_req_if.sink          req,
   input  logic [BYTE_W-1:0] header_byte,
   input  logic [BYTE_W-1:0] live_status,
   output push_type          push_o,
   input  logic              queue_full
);

   localparam int DEPTH  = 5 + 2 * MAX_CHANNELS;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_HDR_RD    = 9'b000000010,
      S_HDR_CHK   = 9'b000000100,
      S_CNT_CHK   = 9'b000001000,
      S_CRC       = 9'b000010000,
      S_CRC_CHK   = 9'b000100000,
      S_EMIT_HI   = 9'b001000000,
      S_EMIT_LO   = 9'b010000000,
      S_EMIT_ZERO = 9'b100000000
   } state_type;

   // Pointer plus offset, modulo the window depth.
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [FILL_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, base} + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [BYTE_W-1:0]  win_mem [DEPTH];
   logic [BYTE_W-1:0]  rdata_ff;
   logic [PTR_W-1:0]   rd_addr;
   logic [FILL_W-1:0]  rd_off;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [FILL_W-1:0]  need_ff, need_in;
   logic [FILL_W-1:0]  idx_ff, idx_in;
   logic [15:0]        crc_ff, crc_in;
   logic [BYTE_W-1:0]  status_ff, status_in;
   logic [BYTE_W-1:0]  hi_ff, hi_in;
   logic [INDEX_W-1:0] k_ff, k_in;

   logic [FILL_W-1:0]  need_calc;
   logic               last_chan;

   // Window memory: one write port for arriving bytes, one registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[wr_addr] <= req.rx_byte;
      end
      rdata_ff <= win_mem[rd_addr];
   end

   assign wr_addr   = wrap_add(head_ff, fill_ff);
   assign rd_addr   = wrap_add(head_ff, rd_off);
   assign need_calc = FILL_W'(5) + FILL_W'({rdata_ff[COUNT_W-1:0], 1'b0});
   assign last_chan = (COUNT_W'(k_ff) + COUNT_W'(1)) == n_ff;
   assign req.ready = (state_ff == S_IDLE);

   // Scan sequencer.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      n_in      = n_ff;
      need_in   = need_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      status_in = status_ff;
      hi_in     = hi_ff;
      k_in      = k_ff;
      rd_off    = '0;
      wr_en     = 1'b0;
      push_o    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               wr_en = 1'b1;
               // A full window loses its oldest byte to make room.
               if (fill_ff == FILL_W'(DEPTH)) begin
                  head_in = wrap_add(head_ff, FILL_W'(1));
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               state_in = S_HDR_RD;
            end
         end

         S_HDR_RD: begin
            if (fill_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_HDR_CHK;
            end
         end

         S_HDR_CHK: begin
            if (rdata_ff != header_byte) begin
               head_in  = wrap_add(head_ff, FILL_W'(1));
               fill_in  = fill_ff - FILL_W'(1);
               state_in = S_HDR_RD;
            end else if (fill_ff < FILL_W'(3)) begin
               state_in = S_IDLE;
            end else begin
               rd_off   = FILL_W'(2);
               state_in = S_CNT_CHK;
            end
         end

         S_CNT_CHK: begin
            if (rdata_ff > BYTE_W'(MAX_CHANNELS)) begin
               head_in  = wrap_add(head_ff, FILL_W'(1));
               fill_in  = fill_ff - FILL_W'(1);
               state_in = S_HDR_RD;
            end else begin
               n_in    = rdata_ff[COUNT_W-1:0];
               need_in = need_calc;
               if (fill_ff < need_calc) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = '0;
                  crc_in   = '0;
                  state_in = S_CRC;
               end
            end
         end

         // One byte of the frame per cycle through the CRC.
         S_CRC: begin
            crc_in = crc16_byte(crc_ff, rdata_ff);
            if (idx_ff == FILL_W'(1)) begin
               status_in = rdata_ff;
            end
            if (idx_ff + FILL_W'(1) == need_ff) begin
               state_in = S_CRC_CHK;
            end else begin
               idx_in = idx_ff + FILL_W'(1);
               rd_off = idx_ff + FILL_W'(1);
            end
         end

         S_CRC_CHK: begin
            if (crc_ff != '0) begin
               head_in  = wrap_add(head_ff, FILL_W'(1));
               fill_in  = fill_ff - FILL_W'(1);
               state_in = S_HDR_RD;
            end else if (status_ff != live_status) begin
               head_in  = wrap_add(head_ff, need_ff);
               fill_in  = fill_ff - need_ff;
               state_in = S_IDLE;
            end else if (n_ff == '0) begin
               state_in = S_EMIT_ZERO;
            end else begin
               k_in     = '0;
               rd_off   = FILL_W'(3);
               state_in = S_EMIT_HI;
            end
         end

         S_EMIT_HI: begin
            hi_in    = rdata_ff;
            rd_off   = FILL_W'(4) + FILL_W'({k_ff, 1'b0});
            state_in = S_EMIT_LO;
         end

         // Hold the low byte address until the queue takes the word.
         S_EMIT_LO: begin
            rd_off = FILL_W'(4) + FILL_W'({k_ff, 1'b0});
            if (!queue_full) begin
               push_o.push               = 1'b1;
               push_o.item.channel_index = k_ff;
               push_o.item.channel_value = {hi_ff, rdata_ff};
               push_o.item.channel_count = n_ff;
               push_o.item.channel_valid = 1'b1;
               push_o.item.last_of_frame = last_chan;
               if (last_chan) begin
                  head_in  = wrap_add(head_ff, need_ff);
                  fill_in  = fill_ff - need_ff;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + INDEX_W'(1);
                  rd_off   = FILL_W'(5) + FILL_W'({k_ff, 1'b0});
                  state_in = S_EMIT_HI;
               end
            end
         end

         // A live frame without channels reports one empty result.
         S_EMIT_ZERO: begin
            if (!queue_full) begin
               push_o.push               = 1'b1;
               push_o.item.last_of_frame = 1'b1;
               head_in  = wrap_add(head_ff, need_ff);
               fill_in  = fill_ff - need_ff;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
   end

   // Working registers of the frame under test.
   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      need_ff   <= need_in;
      idx_ff    <= idx_in;
      crc_ff    <= crc_in;
      status_ff <= status_in;
      hi_ff     <= hi_in;
      k_ff      <= k_in;
   end

endmodule

[hdl/sumd_rsp_queue.sv]
// ----------------------------------------------------------------------------
// SUMD result queue
// Short FIFO between the scanner and the response port; its head entry
// drives the response payload straight from registers.
// ----------------------------------------------------------------------------
module sumd_rsp_queue import sumd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_i,
   output logic     full,
   sumd_rsp_if.source rsp
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;
   rsp_item_type      head_item;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push   = push_i.push && !full;
   assign do_pop    = rsp.valid && rsp.ready;
   assign head_item = entry_ff[rd_ptr_ff];

   assign rsp.valid         = (count_ff != '0);
   assign rsp.channel_index = head_item.channel_index;
   assign rsp.channel_value = head_item.channel_value;
   assign rsp.channel_count = head_item.channel_count;
   assign rsp.channel_valid = head_item.channel_valid;
   assign rsp.last_of_frame = head_item.last_of_frame;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10: begin
            count_in = count_ff + CNT_W'(1);
         end
         2'b01: begin
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_i.item;
      end
   end

endmodule

[hdl/sumd_checker.sv]
// ----------------------------------------------------------------------------
// SUMD parser checker
// Port-level checks on the frame parser, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sumd_checker import sumd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] rsp_channel_index,
   input logic [VALUE_W-1:0] rsp_channel_value,
   input logic [COUNT_W-1:0] rsp_channel_count,
   input logic               rsp_channel_valid,
   input logic               rsp_last_of_frame
);

   // A stalled result stays valid and holds its index, value and last flag.
   `SUMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_channel_index) && $stable(rsp_channel_value) && $stable(rsp_last_of_frame), "stalled result changed")

   // Every accepted byte starts a scan, so the next cycle takes no byte.
   `SUMD_ASSERT_NEXT(a_scan_after_byte, clock, reset, req_valid && req_ready, !req_ready, "byte taken while scan should run")

   // An empty frame result is all zero and closes its frame.
   `SUMD_ASSERT_IMPLY(a_empty_frame, clock, reset, rsp_valid && !rsp_channel_valid, rsp_last_of_frame && (rsp_channel_count == '0) && (rsp_channel_index == '0) && (rsp_channel_value == '0), "malformed empty frame result")

   // A channel result lies inside its frame and marks the last channel.
   `SUMD_ASSERT_IMPLY(a_channel_pos, clock, reset, rsp_valid && rsp_channel_valid, (COUNT_W'(rsp_channel_index) < rsp_channel_count) && (rsp_last_of_frame == (COUNT_W'(rsp_channel_index) + COUNT_W'(1) == rsp_channel_count)), "channel index or last flag inconsistent")

endmodule

bind sumd_frame_parser sumd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_channel_index (rsp_bus.channel_index),
   .rsp_channel_value (rsp_bus.channel_value),
   .rsp_channel_count (rsp_bus.channel_count),
   .rsp_channel_valid (rsp_bus.channel_valid),
   .rsp_last_of_frame (rsp_bus.last_of_frame)
);
